/* design/fpdc_pkg.sv */
package fpdc_pkg;

    localparam int ALT_W    = 24;
    localparam int PITCH_W  = 16;
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 23;
    localparam int STEP_W   = 17;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // floor(now / 1000) = (now * DIV_MAGIC) >> DIV_SHIFT, exact for any 32 bit now
    localparam int DIV_MAGIC_W = 29;
    localparam int DIV_SHIFT   = 38;
    localparam int PROD_W      = TIME_W + DIV_MAGIC_W;
    localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 29'h1062_4DD3;

    // remainder mod 1000 fits in 10 bits, so only the low bits take part
    localparam int REM_W = 10;
    localparam logic [REM_W-1:0] BLINK_CYCLE_MS = 10'd1000;
    localparam logic [REM_W-1:0] BLINK_ON_MS    = 10'd100;

    localparam logic [1:0] MOTION_LEVEL = 2'd0;
    localparam logic [1:0] MOTION_CLIMB = 2'd1;
    localparam logic [1:0] MOTION_FALL  = 2'd2;

    localparam logic [1:0] SIDE_BEFORE = 2'd1;
    localparam logic [1:0] SIDE_AFTER  = 2'd2;

    localparam logic [2:0] PHASE_PAD      = 3'd1;
    localparam logic [2:0] PHASE_ASCENT   = 3'd2;
    localparam logic [2:0] PHASE_APOGEE   = 3'd3;
    localparam logic [2:0] PHASE_DESCENT1 = 3'd4;
    localparam logic [2:0] PHASE_DESCENT2 = 3'd5;
    localparam logic [2:0] PHASE_LANDED   = 3'd6;
    localparam logic [2:0] PHASE_ERROR    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_APOGEE_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUND_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_PER   = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0]         apogee_level;
        logic [LEVEL_W-1:0]         main_deploy_level;
        logic [LEVEL_W-1:0]         ground_level;
        logic [STEP_W-1:0]          climb_step;
        logic signed [PITCH_W-1:0]  pitch_limit;
        logic [PERIOD_W-1:0]        report_period_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [ALT_W-1:0]   altitude;
        logic signed [PITCH_W-1:0] pitch;
        logic [TIME_W-1:0]         now;
        logic [REM_W-1:0]          quot_lo;
    } sample_t;

endpackage

/* design/fpdc_cfg.sv */
module fpdc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [fpdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpdc_pkg::CFG_DATA_W-1:0] cfg_data,
    output fpdc_pkg::cfg_t                 cfg
);
    import fpdc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.apogee_level      <= 23'd270000;
            cfg_reg.main_deploy_level <= 23'd60000;
            cfg_reg.ground_level      <= 23'd3000;
            cfg_reg.climb_step        <= 17'd500;
            cfg_reg.pitch_limit       <= 16'sd1000;
            cfg_reg.report_period_ms  <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_APOGEE_LEVEL: cfg_reg.apogee_level      <= cfg_data[LEVEL_W-1:0];
                REG_MAIN_LEVEL:   cfg_reg.main_deploy_level <= cfg_data[LEVEL_W-1:0];
                REG_GROUND_LEVEL: cfg_reg.ground_level      <= cfg_data[LEVEL_W-1:0];
                REG_CLIMB_STEP:   cfg_reg.climb_step        <= cfg_data[STEP_W-1:0];
                REG_PITCH_LIMIT:  cfg_reg.pitch_limit       <= $signed(cfg_data[PITCH_W-1:0]);
                REG_REPORT_PER:   cfg_reg.report_period_ms  <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/fpdc_front.sv */
module fpdc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [fpdc_pkg::ALT_W-1:0]   altitude_cm,
    input  logic signed [fpdc_pkg::PITCH_W-1:0] pitch_centideg,
    input  logic [fpdc_pkg::TIME_W-1:0]         now_ms,
    input  logic                                take,
    output logic                                smp_valid,
    output fpdc_pkg::sample_t                   smp
);
    import fpdc_pkg::*;

    logic               smp_valid_reg;
    logic               smp_valid_next;
    sample_t            smp_reg;
    logic [PROD_W-1:0]  prod;
    logic               load;

    // quotient by 1000 taken right at the input, the core only needs its low bits
    assign prod = {{DIV_MAGIC_W{1'b0}}, now_ms} * {{TIME_W{1'b0}}, DIV_MAGIC};

    assign sample_stall = smp_valid_reg && !take;
    assign load = sample_valid && !sample_stall;

    always_comb
    begin
        smp_valid_next = smp_valid_reg;
        if (load)
            smp_valid_next = 1'b1;
        else if (take)
            smp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smp_valid_reg <= 1'b0;
        else
            smp_valid_reg <= smp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            smp_reg.altitude <= altitude_cm;
            smp_reg.pitch    <= pitch_centideg;
            smp_reg.now      <= now_ms;
            smp_reg.quot_lo  <= prod[DIV_SHIFT+REM_W-1:DIV_SHIFT];
        end
    end

    assign smp_valid = smp_valid_reg;
    assign smp = smp_reg;

endmodule

/* design/fpdc_core.sv */
module fpdc_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpdc_pkg::cfg_t                      cfg,
    input  logic                                smp_valid,
    input  fpdc_pkg::sample_t                   smp,
    output logic                                take,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [1:0]                          motion,
    output logic [1:0]                          apogee_side,
    output logic [2:0]                          flight_phase,
    output logic                                drogue_fire,
    output logic                                main_fire,
    output logic                                buzzer_on,
    output logic                                report_due,
    output logic [fpdc_pkg::COUNT_W-1:0]        report_number
);
    import fpdc_pkg::*;

    localparam int CMP_W = ALT_W + 2;

    // flight state
    logic signed [ALT_W-1:0] ref_alt_reg;
    logic [TIME_W-1:0]       last_time_reg;
    logic                    climbed_reg;
    logic                    drogue_reg;
    logic                    main_reg;
    logic                    buzzer_reg;
    logic [COUNT_W-1:0]      count_reg;

    logic                    climbed_next;
    logic                    drogue_next;
    logic                    main_next;
    logic                    buzzer_next;
    logic [COUNT_W-1:0]      count_next;

    // result register
    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic [1:0]              motion_reg;
    logic [1:0]              side_reg;
    logic [2:0]              phase_reg;
    logic                    due_reg;

    logic signed [CMP_W-1:0] alt_w;
    logic signed [CMP_W-1:0] ref_w;
    logic signed [CMP_W-1:0] diff;
    logic signed [CMP_W-1:0] step_w;
    logic signed [CMP_W-1:0] apo_w;
    logic signed [CMP_W-1:0] main_w;
    logic signed [CMP_W-1:0] gnd_w;
    logic [REM_W-1:0]        rem;
    logic                    blink;
    logic [TIME_W-1:0]       elapsed;
    logic                    due;
    logic [1:0]              motion_c;
    logic [1:0]              side_c;
    logic [2:0]              phase_c;

    assign take = smp_valid && (!result_valid_reg || !result_stall);

    assign alt_w  = $signed({{2{smp.altitude[ALT_W-1]}}, smp.altitude});
    assign ref_w  = $signed({{2{ref_alt_reg[ALT_W-1]}}, ref_alt_reg});
    assign diff   = alt_w - ref_w;
    assign step_w = $signed({{(CMP_W-STEP_W){1'b0}}, cfg.climb_step});
    assign apo_w  = $signed({{(CMP_W-LEVEL_W){1'b0}}, cfg.apogee_level});
    assign main_w = $signed({{(CMP_W-LEVEL_W){1'b0}}, cfg.main_deploy_level});
    assign gnd_w  = $signed({{(CMP_W-LEVEL_W){1'b0}}, cfg.ground_level});

    // now mod 1000, low bits are enough since the remainder stays below 1024
    assign rem   = smp.now[REM_W-1:0] - REM_W'(smp.quot_lo * BLINK_CYCLE_MS);
    assign blink = rem < BLINK_ON_MS;

    assign elapsed = smp.now - last_time_reg;
    assign due     = elapsed > {{(TIME_W-PERIOD_W){1'b0}}, cfg.report_period_ms};

    always_comb
    begin
        climbed_next = climbed_reg;
        drogue_next  = drogue_reg;
        main_next    = main_reg;
        buzzer_next  = buzzer_reg;

        if (diff > step_w)
        begin
            motion_c     = MOTION_CLIMB;
            climbed_next = 1'b1;
        end
        else if (diff < -step_w)
            motion_c = MOTION_FALL;
        else
            motion_c = MOTION_LEVEL;

        if (motion_c == MOTION_CLIMB || (motion_c == MOTION_LEVEL && !climbed_reg))
            side_c = SIDE_BEFORE;
        else
            side_c = SIDE_AFTER;

        // strict compares, a value sitting on a threshold falls to the error phase
        if (side_c == SIDE_BEFORE && alt_w < gnd_w)
            phase_c = PHASE_PAD;
        else if (side_c == SIDE_BEFORE && alt_w > gnd_w && alt_w < apo_w)
            phase_c = PHASE_ASCENT;
        else if (alt_w > apo_w && smp.pitch < cfg.pitch_limit)
        begin
            phase_c     = PHASE_APOGEE;
            drogue_next = 1'b1;
        end
        else if (side_c == SIDE_AFTER && alt_w < apo_w && alt_w > main_w)
            phase_c = PHASE_DESCENT1;
        else if (side_c == SIDE_AFTER && alt_w < main_w && alt_w > gnd_w)
        begin
            phase_c   = PHASE_DESCENT2;
            main_next = 1'b1;
        end
        else if (side_c == SIDE_AFTER && alt_w < gnd_w)
        begin
            phase_c     = PHASE_LANDED;
            buzzer_next = 1'b1;
        end
        else
        begin
            phase_c     = PHASE_ERROR;
            buzzer_next = blink;
        end
    end

    assign count_next = due ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (take)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            ref_alt_reg      <= '0;
            last_time_reg    <= '0;
            climbed_reg      <= 1'b0;
            drogue_reg       <= 1'b0;
            main_reg         <= 1'b0;
            buzzer_reg       <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (take)
            begin
                climbed_reg <= climbed_next;
                drogue_reg  <= drogue_next;
                main_reg    <= main_next;
                buzzer_reg  <= buzzer_next;
                count_reg   <= count_next;
                if (due)
                begin
                    last_time_reg <= smp.now;
                    ref_alt_reg   <= smp.altitude;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            motion_reg <= motion_c;
            side_reg   <= side_c;
            phase_reg  <= phase_c;
            due_reg    <= due;
        end
    end

    assign result_valid  = result_valid_reg;
    assign motion        = motion_reg;
    assign apogee_side   = side_reg;
    assign flight_phase  = phase_reg;
    assign drogue_fire   = drogue_reg;
    assign main_fire     = main_reg;
    assign buzzer_on     = buzzer_reg;
    assign report_due    = due_reg;
    assign report_number = count_reg;

`ifndef SYNTH
    a_drogue_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        drogue_reg |=> drogue_reg)
        else $error("drogue latch dropped");

    a_main_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        main_reg |=> main_reg)
        else $error("main latch dropped");

    a_apogee_fires: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && phase_reg == PHASE_APOGEE |-> drogue_reg)
        else $error("apogee phase without drogue drive");

    a_landed_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && phase_reg == PHASE_LANDED |-> buzzer_reg)
        else $error("landed phase without buzzer");

    a_report_count: assert property (@(posedge clk) disable iff (!rst_n)
        take && due |=> count_reg == $past(count_reg) + 1'b1)
        else $error("report count did not advance");
`endif

endmodule

/* design/flight_phase_deploy_controller.sv */
// flight phase and deploy controller
//
// sample channel: sample_valid / sample_stall with altitude_cm, pitch_centideg
// and now_ms; a beat moves when valid is high and stall is low.
// result channel: result_valid / result_stall with motion, apogee_side,
// flight_phase, drogue_fire, main_fire, buzzer_on, report_due, report_number.
// one result beat per sample beat, in order.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
// always high, unknown index ignored; the user lets writes go in only while no
// sample is in flight; the block itself does not enforce this.
//
// an accepted sample passes the input register with the divide-by-1000 product,
// then phase logic into the result register, before its result beat can move.
// throughput is one sample per cycle while result_stall is low, limited by the
// flight state that each sample updates in the result stage.
// while the receiver stalls the result is held and one more sample can wait in
// the input register; after that sample_stall goes high.
// reset clears the flight state, latches, report count and reference altitude,
// and loads the threshold registers with their defaults.
module flight_phase_deploy_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [fpdc_pkg::ALT_W-1:0]     altitude_cm,
    input  logic signed [fpdc_pkg::PITCH_W-1:0]   pitch_centideg,
    input  logic [fpdc_pkg::TIME_W-1:0]           now_ms,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [1:0]                            motion,
    output logic [1:0]                            apogee_side,
    output logic [2:0]                            flight_phase,
    output logic                                  drogue_fire,
    output logic                                  main_fire,
    output logic                                  buzzer_on,
    output logic                                  report_due,
    output logic [fpdc_pkg::COUNT_W-1:0]          report_number,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpdc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fpdc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fpdc_pkg::*;

    cfg_t    cfg;
    sample_t smp;
    logic    smp_valid;
    logic    take;

    assign cfg_ready = 1'b1;

    fpdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fpdc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .altitude_cm    (altitude_cm),
        .pitch_centideg (pitch_centideg),
        .now_ms         (now_ms),
        .take           (take),
        .smp_valid      (smp_valid),
        .smp            (smp)
    );

    fpdc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .smp_valid     (smp_valid),
        .smp           (smp),
        .take          (take),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .motion        (motion),
        .apogee_side   (apogee_side),
        .flight_phase  (flight_phase),
        .drogue_fire   (drogue_fire),
        .main_fire     (main_fire),
        .buzzer_on     (buzzer_on),
        .report_due    (report_due),
        .report_number (report_number)
    );

endmodule
